// ===== src/srl_pkg.sv =====
`timescale 1ns / 1ps

package srl_pkg;

    localparam logic [7:0] C_CHAR_S   = 8'h53;
    localparam logic [7:0] C_CHAR_0   = 8'h30;
    localparam logic [7:0] C_CHAR_1   = 8'h31;
    localparam logic [7:0] C_CHAR_3   = 8'h33;
    localparam logic [7:0] C_CHAR_5   = 8'h35;
    localparam logic [7:0] C_CHAR_7   = 8'h37;
    localparam logic [7:0] C_CHAR_9   = 8'h39;
    localparam logic [7:0] C_CHAR_UA  = 8'h41;
    localparam logic [7:0] C_CHAR_UF  = 8'h46;
    localparam logic [7:0] C_CHAR_LA  = 8'h61;
    localparam logic [7:0] C_CHAR_LF  = 8'h66;
    localparam logic [7:0] C_CHAR_SP  = 8'h20;
    localparam logic [7:0] C_CHAR_TAB = 8'h09;
    localparam logic [7:0] C_CHAR_LF_ = 8'h0A;
    localparam logic [7:0] C_CHAR_VT  = 8'h0B;
    localparam logic [7:0] C_CHAR_FF  = 8'h0C;
    localparam logic [7:0] C_CHAR_CR  = 8'h0D;

    localparam int ADDR_W = 14;

    typedef enum logic [3:0] {
        PH_LINE  = 4'd0,
        PH_TYPE  = 4'd1,
        PH_COUNT = 4'd2,
        PH_ADDR  = 4'd3,
        PH_DATA  = 4'd4,
        PH_SKIP  = 4'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_RUN    = 2'd0,
        ST_DONE   = 2'd1,
        ST_SYNTAX = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] code;
        logic [3:0] hex;
        logic       is_hex;
        logic       is_blank;
        logic       is_s;
        logic       is_newline;
        logic       is_skip_type;
        logic       is_data_type;
        logic       is_end_type;
    } t_char_info;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        t_status           status;
    } t_result;

endpackage

// ===== src/srl_char_class.sv =====
`timescale 1ns / 1ps

module srl_char_class (
    input  logic [7:0]          i_char,
    output srl_pkg::t_char_info o_info
);
    import srl_pkg::*;

    logic w_digit;
    logic w_alpha;

    assign w_digit = (i_char >= C_CHAR_0) && (i_char <= C_CHAR_9);
    assign w_alpha = ((i_char >= C_CHAR_UA) && (i_char <= C_CHAR_UF))
                  || ((i_char >= C_CHAR_LA) && (i_char <= C_CHAR_LF));

    always_comb begin
        o_info.code         = i_char;
        o_info.is_hex       = w_digit || w_alpha;
        o_info.hex          = w_digit ? i_char[3:0] : (i_char[3:0] + 4'd9);
        o_info.is_blank     = (i_char == C_CHAR_SP) || (i_char == C_CHAR_TAB)
                           || (i_char == C_CHAR_VT) || (i_char == C_CHAR_FF)
                           || (i_char == C_CHAR_CR);
        o_info.is_s         = (i_char == C_CHAR_S);
        o_info.is_newline   = (i_char == C_CHAR_LF_);
        o_info.is_skip_type = (i_char == C_CHAR_0) || (i_char == C_CHAR_5);
        o_info.is_data_type = (i_char >= C_CHAR_1) && (i_char <= C_CHAR_3);
        o_info.is_end_type  = (i_char >= C_CHAR_7) && (i_char <= C_CHAR_9);
    end

endmodule

// ===== src/srl_parser.sv =====
`timescale 1ns / 1ps

module srl_parser #(
    parameter int MEM_BYTES = 16384
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  srl_pkg::t_char_info i_info,
    output srl_pkg::t_result    o_result
);
    import srl_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [1:0]  r_kind,   n_kind;
    logic [7:0]  r_bytes,  n_bytes;
    logic [3:0]  r_digits, n_digits;
    logic [31:0] r_addr,   n_addr;
    logic [3:0]  r_high,   n_high;
    logic        r_nib,    n_nib;
    t_status     r_status, n_status;

    logic [7:0]  w_cnt;
    logic [7:0]  w_skip;
    logic [3:0]  w_digits_dec;
    logic [7:0]  w_bytes_dec;
    logic        w_in_range;

    assign w_cnt        = {r_high, i_info.hex};
    assign w_skip       = 8'({1'b0, r_kind} + 3'd2);
    assign w_digits_dec = r_digits - 4'd1;
    assign w_bytes_dec  = r_bytes - 8'd1;
    assign w_in_range   = r_addr < 32'(MEM_BYTES);

    always_comb begin
        n_phase = r_phase;
        if (r_status == ST_RUN) begin
            case (r_phase)
                PH_LINE: begin
                    if (i_info.is_s) n_phase = PH_TYPE;
                end
                PH_TYPE: begin
                    if (i_info.is_skip_type) n_phase = PH_SKIP;
                    else if (i_info.is_data_type) n_phase = PH_COUNT;
                end
                PH_COUNT: begin
                    if (i_info.is_hex && r_nib) n_phase = PH_ADDR;
                end
                PH_ADDR: begin
                    if (i_info.is_hex && (w_digits_dec == 4'd0)) begin
                        n_phase = (r_bytes == 8'd0) ? PH_SKIP : PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (i_info.is_hex && r_nib && w_in_range && (w_bytes_dec == 8'd0)) begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (i_info.is_newline) n_phase = PH_LINE;
                end
                default: begin
                    n_phase = PH_LINE;
                end
            endcase
        end
    end

    always_comb begin
        n_kind            = r_kind;
        n_bytes           = r_bytes;
        n_digits          = r_digits;
        n_addr            = r_addr;
        n_high            = r_high;
        n_nib             = r_nib;
        n_status          = r_status;
        o_result.wr_en    = 1'b0;
        o_result.wr_addr  = '0;
        o_result.wr_data  = '0;
        if (r_status == ST_RUN) begin
            case (r_phase)
                PH_LINE: begin
                    if (!i_info.is_s && !i_info.is_blank) n_status = ST_SYNTAX;
                end
                PH_TYPE: begin
                    if (i_info.is_data_type) begin
                        n_kind = i_info.code[1:0];
                        n_nib  = 1'b0;
                    end else if (i_info.is_end_type) begin
                        n_status = ST_DONE;
                    end else if (!i_info.is_skip_type) begin
                        n_status = ST_SYNTAX;
                    end
                end
                PH_COUNT: begin
                    if (!i_info.is_hex) begin
                        n_status = ST_SYNTAX;
                    end else if (!r_nib) begin
                        n_high = i_info.hex;
                        n_nib  = 1'b1;
                    end else begin
                        n_bytes  = (w_cnt > w_skip) ? (w_cnt - w_skip) : 8'd0;
                        n_nib    = 1'b0;
                        n_digits = {4'({1'b0, r_kind} + 3'd1)} << 1;
                        n_addr   = '0;
                    end
                end
                PH_ADDR: begin
                    if (!i_info.is_hex) begin
                        n_status = ST_SYNTAX;
                    end else begin
                        n_addr   = {r_addr[27:0], i_info.hex};
                        n_digits = w_digits_dec;
                        if (w_digits_dec == 4'd0) n_nib = 1'b0;
                    end
                end
                PH_DATA: begin
                    if (!i_info.is_hex) begin
                        n_status = ST_SYNTAX;
                    end else if (!r_nib) begin
                        n_high = i_info.hex;
                        n_nib  = 1'b1;
                    end else begin
                        n_nib = 1'b0;
                        if (!w_in_range) begin
                            n_status = ST_RANGE;
                        end else begin
                            o_result.wr_en   = 1'b1;
                            o_result.wr_addr = r_addr[ADDR_W-1:0];
                            o_result.wr_data = {r_high, i_info.hex};
                            n_addr           = r_addr + 32'd1;
                            n_bytes          = w_bytes_dec;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        o_result.status = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LINE;
            r_kind   <= '0;
            r_bytes  <= '0;
            r_digits <= '0;
            r_addr   <= '0;
            r_high   <= '0;
            r_nib    <= 1'b0;
            r_status <= ST_RUN;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_kind   <= n_kind;
            r_bytes  <= n_bytes;
            r_digits <= n_digits;
            r_addr   <= n_addr;
            r_high   <= n_high;
            r_nib    <= n_nib;
            r_status <= n_status;
        end
    end

endmodule

// ===== src/srecord_memory_loader.sv =====
`timescale 1ns / 1ps

// S-record loader: takes S-record text one character per word and returns one
// result word per character, holding a memory byte write (tuser high) and the
// load status after that character (running, done, syntax error, out of range;
// errors and done are sticky until reset). A character passes from the input
// register through the parser to the output register, and a new one is
// accepted every cycle unless the output register is held by back-pressure;
// the parser's state registers, updated once per character, set that rate.
// Writes at or beyond MEM_BYTES are refused with the range status.
module srecord_memory_loader #(
    parameter int MEM_BYTES = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_in
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [13:0] wr_addr, [21:14] wr_data, [23:22] status
    output logic        o_m_axis_tuser    // [0] wr_en
);
    import srl_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_out_valid;
    t_result    r_out;

    logic       w_step;
    t_char_info w_info;
    t_result    w_result;

    assign w_step          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_step;

    srl_char_class u_class (
        .i_char (r_in_char),
        .o_info (w_info)
    );

    srl_parser #(
        .MEM_BYTES (MEM_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_info   (w_info),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) r_in_valid <= i_s_axis_tvalid;
            if (w_step) r_out_valid <= 1'b1;
            else if (i_m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) r_in_char <= i_s_axis_tdata;
        if (w_step) r_out <= w_result;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.wr_en;
    assign o_m_axis_tdata  = {r_out.status, r_out.wr_data, r_out.wr_addr};

endmodule
